// ===== rtl/owb_pkg.sv =====
package owb_pkg;

   localparam int CSR_WIDTH = 12;
   localparam int REG_COUNT = 8;
   localparam int REG_INDEX_WIDTH = 3;
   localparam int BYTE_WIDTH = 8;
   localparam int BIT_INDEX_WIDTH = 3;
   localparam int CMD_WIDTH = 3;

   // Command codes on the request channel.
   localparam logic [CMD_WIDTH-1:0] CMD_RESET      = 3'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_WRITE_BYTE = 3'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_READ_BYTE  = 3'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_WRITE_BIT  = 3'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_READ_BIT   = 3'd4;

   // Timing register indexes.
   localparam logic [REG_INDEX_WIDTH-1:0] REG_RESET_LOW     = 3'd0;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_PRESENCE_WAIT = 3'd1;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_RESET_TAIL    = 3'd2;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_WRITE_LOW     = 3'd3;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_WRITE_HOLD    = 3'd4;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_READ_LOW      = 3'd5;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_READ_SAMPLE   = 3'd6;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_READ_TAIL     = 3'd7;

   typedef logic [REG_COUNT-1:0][CSR_WIDTH-1:0] cfg_array_type;

   localparam cfg_array_type CFG_RESET_VALUES = {
      12'd54, 12'd5, 12'd5, 12'd54, 12'd14, 12'd480, 12'd70, 12'd480
   };

   typedef struct packed {
      logic                  start_req;
      logic [CMD_WIDTH-1:0]  command;
      logic [BYTE_WIDTH-1:0] write_data;
      logic                  line_in;
   } req_type;

   typedef struct packed {
      logic                  drive_low;
      logic                  busy_res;
      logic                  done_res;
      logic                  presence_level;
      logic [BYTE_WIDTH-1:0] read_data;
   } rsp_type;

   // A tick after classification: go marks a legal command start.
   typedef struct packed {
      logic                  go;
      logic [CMD_WIDTH-1:0]  op;
      logic [BYTE_WIDTH-1:0] bits;
      logic                  line_in;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_LOW  = 4'b0010,
      PH_MID  = 4'b0100,
      PH_TAIL = 4'b1000
   } phase_type;

endpackage

// ===== rtl/owb_front.sv =====
module owb_front (
   input  owb_pkg::req_type  req_data,
   output owb_pkg::item_type item
);
   import owb_pkg::*;

   logic legal;

   always_comb begin
      legal = req_data.command inside {CMD_RESET, CMD_WRITE_BYTE, CMD_READ_BYTE,
                                       CMD_WRITE_BIT, CMD_READ_BIT};
      item.go      = req_data.start_req & legal;
      item.op      = req_data.command;
      item.line_in = req_data.line_in;
      case (req_data.command)
         CMD_WRITE_BYTE: item.bits = req_data.write_data;
         CMD_WRITE_BIT:  item.bits = {{(BYTE_WIDTH-1){1'b0}}, |req_data.write_data};
         default:        item.bits = '0;
      endcase
   end

endmodule

// ===== rtl/owb_queue.sv =====
module owb_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  owb_pkg::item_type        push_item,
   output logic                     full,
   input  logic                     pop,
   output owb_pkg::queue_head_type  head
);
   import owb_pkg::*;

   item_type   entry_ff [2];
   item_type   entry_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign do_push    = push & ~full;
   assign do_pop     = pop & (count_ff != 2'd0);
   assign head.valid = (count_ff != 2'd0);
   assign head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         entry_in[wr_ptr_ff] = push_item;
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (do_pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/owb_back.sv =====
module owb_back #(
   parameter int TICK_COUNT_WIDTH = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  owb_pkg::cfg_array_type  cfg,
   input  owb_pkg::queue_head_type head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output owb_pkg::rsp_type        rsp_data
);
   import owb_pkg::*;

   localparam int TW = TICK_COUNT_WIDTH;

   logic [TW-1:0]              span [REG_COUNT];
   logic [CMD_WIDTH-1:0]       op_ff, op_in;
   phase_type                  phase_ff, phase_in;
   logic [TW-1:0]              cnt_ff, cnt_in;
   logic [BIT_INDEX_WIDTH-1:0] bit_ff, bit_in;
   logic [BYTE_WIDTH-1:0]      shift_ff, shift_in;
   logic                       pres_ff, pres_in;
   logic [BYTE_WIDTH-1:0]      rcv_ff, rcv_in;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_data_ff, rsp_data_in;
   logic                       fire;

   // A tick count whose used bits are zero behaves as one tick.
   always_comb begin
      for (int r = 0; r < REG_COUNT; r++) begin
         span[r] = (TW'(cfg[r]) == '0) ? TW'(1) : TW'(cfg[r]);
      end
   end

   assign fire      = head.valid & (~rsp_valid_ff | ~rsp_stall);
   assign pop       = fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      logic          is_write;
      logic          is_read;
      logic          is_byte;
      logic [TW-1:0] low_span;
      logic [TW-1:0] mid_span;
      logic          drive;
      logic          busy;
      logic          done;

      op_in    = op_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      pres_in  = pres_ff;
      rcv_in   = rcv_ff;
      drive    = 1'b0;
      busy     = 1'b0;
      done     = 1'b0;

      if (phase_ff == PH_IDLE && head.item.go) begin
         op_in    = head.item.op;
         bit_in   = '0;
         shift_in = head.item.bits;
         phase_in = PH_LOW;
      end

      is_write = (op_in == CMD_WRITE_BYTE) || (op_in == CMD_WRITE_BIT);
      is_read  = (op_in == CMD_READ_BYTE) || (op_in == CMD_READ_BIT);
      is_byte  = (op_in == CMD_WRITE_BYTE) || (op_in == CMD_READ_BYTE);
      low_span = (op_in == CMD_RESET) ? span[REG_RESET_LOW]
               : (is_write ? span[REG_WRITE_LOW] : span[REG_READ_LOW]);
      mid_span = (op_in == CMD_RESET) ? span[REG_PRESENCE_WAIT]
               : (is_write ? span[REG_WRITE_HOLD] : span[REG_READ_SAMPLE]);

      if (phase_ff == PH_IDLE && head.item.go) begin
         cnt_in = low_span;
      end

      if (phase_in != PH_IDLE) begin
         busy = 1'b1;
         if (phase_in == PH_LOW) begin
            drive = 1'b1;
         end else if (phase_in == PH_MID && is_write) begin
            drive = ~shift_in[bit_in];
         end
         cnt_in = cnt_in - TW'(1);
         if (cnt_in == '0) begin
            case (phase_in)
               PH_LOW: begin
                  phase_in = PH_MID;
                  cnt_in   = mid_span;
               end
               PH_MID: begin
                  if (op_in == CMD_RESET) begin
                     pres_in  = head.item.line_in;
                     phase_in = PH_TAIL;
                     cnt_in   = span[REG_RESET_TAIL];
                  end else if (is_read) begin
                     shift_in[bit_in] = shift_in[bit_in] | head.item.line_in;
                     phase_in = PH_TAIL;
                     cnt_in   = span[REG_READ_TAIL];
                  end else begin
                     done = 1'b1;
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
            // The end of a slot either opens the next bit of a byte or closes the command.
            if (done) begin
               if (op_in != CMD_RESET && is_byte && bit_in != '1) begin
                  done     = 1'b0;
                  bit_in   = bit_in + BIT_INDEX_WIDTH'(1);
                  phase_in = PH_LOW;
                  cnt_in   = low_span;
               end else begin
                  if (is_read) begin
                     rcv_in = shift_in;
                  end
                  phase_in = PH_IDLE;
               end
            end
         end
      end

      rsp_data_in.drive_low      = drive;
      rsp_data_in.busy_res       = busy;
      rsp_data_in.done_res       = done;
      rsp_data_in.presence_level = pres_in;
      rsp_data_in.read_data      = rcv_in;
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
         cnt_ff      <= cnt_in;
         bit_ff      <= bit_in;
         shift_ff    <= shift_in;
      end
      if (reset) begin
         op_ff        <= CMD_RESET;
         phase_ff     <= PH_IDLE;
         pres_ff      <= 1'b1;
         rcv_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            op_ff    <= op_in;
            phase_ff <= phase_in;
            pres_ff  <= pres_in;
            rcv_ff   <= rcv_in;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (~rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== rtl/one_wire_bus_master.sv =====
// Channel    Direction  Handshake              Content
// req_       in         req_valid / req_stall  one bus tick: start, command, data, line level
// rsp_       out        rsp_valid / rsp_stall  one result per tick: drive, busy, done, data
// csr_       in         csr_wr_en              timing register write, index and value
//
// Every request is one bus tick and yields exactly one response; one request per clock
// is sustained while rsp_stall is low. A taken request is written into the two-entry
// queue, and the tick engine pops it from the head and registers its response.
// req_stall rises only when the queue holds two requests that the stalled response
// side has not drained. Reset is synchronous and restores the default timing.
module one_wire_bus_master #(
   parameter int TICK_COUNT_WIDTH = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  owb_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output owb_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [owb_pkg::REG_INDEX_WIDTH-1:0]   csr_index,
   input  logic [owb_pkg::CSR_WIDTH-1:0]         csr_wdata
);
   import owb_pkg::*;

   cfg_array_type  cfg_ff, cfg_in;
   item_type       item;
   queue_head_type head;
   logic           full;
   logic           pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         cfg_in[csr_index] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET_VALUES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = full;

   owb_front u_front (
      .req_data (req_data),
      .item     (item)
   );

   owb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_item (item),
      .full      (full),
      .pop       (pop),
      .head      (head)
   );

   owb_back #(
      .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/owb_checker.sv =====
module owb_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input owb_pkg::rsp_type rsp_data
);
   import owb_pkg::*;

   logic                  seen_ff;
   logic                  last_pres_ff;
   logic [BYTE_WIDTH-1:0] last_rd_ff;
   logic                  rsp_take;

   assign rsp_take = rsp_valid & ~rsp_stall;

   always_ff @(posedge clock) begin
      if (rsp_take) begin
         last_pres_ff <= rsp_data.presence_level;
         last_rd_ff   <= rsp_data.read_data;
      end
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_take) begin
         seen_ff <= 1'b1;
      end
   end

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> rsp_data.busy_res)
      else $error("done without busy");

   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.drive_low |-> rsp_data.busy_res)
      else $error("line driven while idle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

   // Between commands the reported presence and read values must not move.
   a_idle_keeps: assert property (@(posedge clock) disable iff (reset)
      rsp_take && seen_ff && !rsp_data.busy_res |->
         rsp_data.presence_level == last_pres_ff && rsp_data.read_data == last_rd_ff)
      else $error("idle tick changed reported values");

endmodule

bind one_wire_bus_master owb_checker u_owb_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/one_wire_bus_master_tb.sv =====
`timescale 1ns / 100ps

module one_wire_bus_master_tb;
   import owb_pkg::*;

   // Command codes that the block must ignore.
   localparam logic [CMD_WIDTH-1:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [CMD_WIDTH-1:0] CMD_UNUSED_MD = 3'd6;
   localparam logic [CMD_WIDTH-1:0] CMD_UNUSED_HI = 3'd7;

   // Short timing: reset 6/3/5, write 2/3, read 1/2/3.
   localparam cfg_array_type SHORT_TIMING = {
      12'd3, 12'd2, 12'd1, 12'd3, 12'd2, 12'd5, 12'd3, 12'd6
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [REG_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_WIDTH-1:0] csr_wdata = '0;

   one_wire_bus_master u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("one_wire_bus_master_tb: FAIL");
      $finish;
   end

   // Bus master state as the testbench sees it.
   phase_type            bus_phase;
   logic [CMD_WIDTH-1:0] bus_op;
   logic [CSR_WIDTH-1:0] slot_count;
   logic [2:0]           bit_pos;
   logic [7:0]           bit_buf;
   logic                 presence_seen;
   logic [7:0]           last_read;
   logic [CSR_WIDTH-1:0] timing [REG_COUNT];

   rsp_type bus_outcomes [$];
   int      mismatches = 0;
   bit      steady = 1'b0;

   typedef struct {
      req_type stim;
      int      reps;
      bit      typed;
      rsp_type want;
   } step_row;

   // Default timing: write bit 14/54, read bit 5/5/54.
   step_row boot_rows [11] = '{
      '{'{1'b0, CMD_RESET,      8'h00, 1'b1},    1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00}},
      '{'{1'b1, CMD_UNUSED_LO,  8'h5A, 1'b0},    1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00}},
      '{'{1'b1, CMD_UNUSED_MD,  8'h3C, 1'b1},    1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00}},
      '{'{1'b1, CMD_UNUSED_HI,  8'hFF, 1'b1},    1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00}},
      '{'{1'b1, CMD_WRITE_BIT,  8'h80, 1'b0},    1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00}},
      '{'{1'b1, CMD_WRITE_BYTE, 8'hFF, 1'b0},   66, 1'b0, '0},
      // This request lands on the last tick of the write slot and must be dropped.
      '{'{1'b1, CMD_READ_BIT,   8'h00, 1'b0},    1, 1'b0, '0},
      '{'{1'b0, CMD_RESET,      8'h00, 1'b1},    1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00}},
      '{'{1'b1, CMD_READ_BIT,   8'h00, 1'b1},    1, 1'b0, '0},
      '{'{1'b0, CMD_RESET,      8'h00, 1'b1},   63, 1'b0, '0},
      '{'{1'b0, CMD_RESET,      8'h00, 1'b1},    1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h01}}
   };

   // Short timing: reset 14 ticks, write byte 40, read byte 48, read bit 6, write bit 5.
   step_row script [21] = '{
      '{'{1'b1, CMD_RESET,      8'h00, 1'b0},    1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 8'h01}},
      '{'{1'b1, CMD_WRITE_BYTE, 8'hFF, 1'b0},   12, 1'b0, '0},
      // This request lands on the last tick of the reset and must be dropped.
      '{'{1'b1, CMD_WRITE_BIT,  8'h01, 1'b0},    1, 1'b0, '0},
      '{'{1'b0, CMD_RESET,      8'h00, 1'b1},    1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h01}},
      '{'{1'b1, CMD_WRITE_BYTE, 8'hA5, 1'b1},    1, 1'b0, '0},
      '{'{1'b0, CMD_RESET,      8'h00, 1'b1},   44, 1'b0, '0},
      '{'{1'b1, CMD_WRITE_BYTE, 8'h00, 1'b0},    1, 1'b0, '0},
      '{'{1'b0, CMD_RESET,      8'h00, 1'b0},   44, 1'b0, '0},
      '{'{1'b1, CMD_READ_BYTE,  8'h00, 1'b1},    1, 1'b0, '0},
      '{'{1'b0, CMD_RESET,      8'h00, 1'b1},   50, 1'b0, '0},
      '{'{1'b0, CMD_RESET,      8'h00, 1'b1},    1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'hFF}},
      '{'{1'b1, CMD_READ_BIT,   8'hFF, 1'b0},    1, 1'b0, '0},
      '{'{1'b0, CMD_RESET,      8'h00, 1'b0},    8, 1'b0, '0},
      '{'{1'b0, CMD_RESET,      8'h00, 1'b0},    1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00}},
      '{'{1'b1, CMD_WRITE_BIT,  8'h80, 1'b1},    1, 1'b0, '0},
      '{'{1'b0, CMD_RESET,      8'h00, 1'b1},    8, 1'b0, '0},
      '{'{1'b1, CMD_WRITE_BIT,  8'h00, 1'b1},    1, 1'b0, '0},
      '{'{1'b0, CMD_RESET,      8'h00, 1'b1},    8, 1'b0, '0},
      '{'{1'b1, CMD_RESET,      8'hFF, 1'b1},    1, 1'b0, '0},
      '{'{1'b0, CMD_RESET,      8'h00, 1'b1},   16, 1'b0, '0},
      '{'{1'b0, CMD_RESET,      8'h00, 1'b1},    1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00}}
   };

   task automatic clear_bus_state();
      timing[REG_RESET_LOW]     = 12'd480;
      timing[REG_PRESENCE_WAIT] = 12'd70;
      timing[REG_RESET_TAIL]    = 12'd480;
      timing[REG_WRITE_LOW]     = 12'd14;
      timing[REG_WRITE_HOLD]    = 12'd54;
      timing[REG_READ_LOW]      = 12'd5;
      timing[REG_READ_SAMPLE]   = 12'd5;
      timing[REG_READ_TAIL]     = 12'd54;
      bus_phase     = PH_IDLE;
      bus_op        = CMD_RESET;
      slot_count    = '0;
      bit_pos       = '0;
      bit_buf       = '0;
      presence_seen = 1'b1;
      last_read     = '0;
   endtask

   // A register left at zero still lasts one tick.
   function automatic logic [CSR_WIDTH-1:0] ticks_of(input logic [REG_INDEX_WIDTH-1:0] idx);
      return (timing[idx] == '0) ? 12'd1 : timing[idx];
   endfunction

   function automatic bit op_writes();
      return bus_op == CMD_WRITE_BYTE || bus_op == CMD_WRITE_BIT;
   endfunction

   function automatic logic [CSR_WIDTH-1:0] low_ticks();
      if (bus_op == CMD_RESET)
         return ticks_of(REG_RESET_LOW);
      return op_writes() ? ticks_of(REG_WRITE_LOW) : ticks_of(REG_READ_LOW);
   endfunction

   function automatic logic [CSR_WIDTH-1:0] mid_ticks();
      if (bus_op == CMD_RESET)
         return ticks_of(REG_PRESENCE_WAIT);
      return op_writes() ? ticks_of(REG_WRITE_HOLD) : ticks_of(REG_READ_SAMPLE);
   endfunction

   // Ends one bit slot; a byte moves on to its next bit. Returns the done flag.
   function automatic logic close_slot();
      if ((bus_op == CMD_WRITE_BYTE || bus_op == CMD_READ_BYTE) && bit_pos < BYTE_WIDTH - 1) begin
         bit_pos    = bit_pos + 3'd1;
         bus_phase  = PH_LOW;
         slot_count = low_ticks();
         return 1'b0;
      end
      if (!op_writes())
         last_read = bit_buf;
      bus_phase = PH_IDLE;
      return 1'b1;
   endfunction

   function automatic rsp_type advance_bus(input req_type stim);
      rsp_type outcome;
      outcome = '0;
      if (bus_phase == PH_IDLE && stim.start_req && stim.command <= CMD_READ_BIT) begin
         bus_op  = stim.command;
         bit_pos = '0;
         if (stim.command == CMD_WRITE_BYTE)
            bit_buf = stim.write_data;
         else if (stim.command == CMD_WRITE_BIT)
            bit_buf = {7'd0, stim.write_data != 8'h00};
         else
            bit_buf = '0;
         bus_phase  = PH_LOW;
         slot_count = low_ticks();
      end
      if (bus_phase != PH_IDLE) begin
         outcome.busy_res = 1'b1;
         if (bus_phase == PH_LOW)
            outcome.drive_low = 1'b1;
         else if (bus_phase == PH_MID && op_writes())
            outcome.drive_low = ~bit_buf[bit_pos];
         slot_count = slot_count - 12'd1;
         if (slot_count == '0) begin
            case (bus_phase)
               PH_LOW: begin
                  bus_phase  = PH_MID;
                  slot_count = mid_ticks();
               end
               PH_MID: begin
                  if (bus_op == CMD_RESET) begin
                     presence_seen = stim.line_in;
                     bus_phase     = PH_TAIL;
                     slot_count    = ticks_of(REG_RESET_TAIL);
                  end else if (op_writes()) begin
                     outcome.done_res = close_slot();
                  end else begin
                     bit_buf[bit_pos] = bit_buf[bit_pos] | stim.line_in;
                     bus_phase        = PH_TAIL;
                     slot_count       = ticks_of(REG_READ_TAIL);
                  end
               end
               default: begin
                  if (bus_op == CMD_RESET) begin
                     bus_phase        = PH_IDLE;
                     outcome.done_res = 1'b1;
                  end else begin
                     outcome.done_res = close_slot();
                  end
               end
            endcase
         end
      end
      outcome.presence_level = presence_seen;
      outcome.read_data      = last_read;
      return outcome;
   endfunction

   function automatic req_type random_tick();
      req_type stim;
      int pick;
      stim.start_req = ($urandom_range(99) < 35);
      if ($urandom_range(99) < 90)
         stim.command = CMD_WIDTH'($urandom_range(CMD_READ_BIT, CMD_RESET));
      else
         stim.command = CMD_WIDTH'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
      pick = $urandom_range(9);
      if (pick == 0)
         stim.write_data = 8'h00;
      else if (pick == 1)
         stim.write_data = 8'hFF;
      else
         stim.write_data = 8'($urandom_range(255));
      stim.line_in = 1'($urandom_range(1));
      return stim;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_tick(input req_type stim, input bit typed, input rsp_type want);
      rsp_type outcome;
      while (!steady && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= stim;
      do
         @(posedge clock);
      while (req_stall);
      outcome = advance_bus(stim);
      bus_outcomes.push_back(typed ? want : outcome);
      @(negedge clock);
   endtask

   // Finishes any command in flight and waits for the block to drain.
   task automatic settle();
      while (bus_phase != PH_IDLE)
         send_tick(random_tick(), 1'b0, '0);
      req_valid <= 1'b0;
      while (bus_outcomes.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic load_timing(input int lo, input int hi);
      logic [CSR_WIDTH-1:0] value;
      settle();
      for (int i = 0; i < REG_COUNT; i++) begin
         value = CSR_WIDTH'($urandom_range(hi, lo));
         csr_wr_en <= 1'b1;
         csr_index <= REG_INDEX_WIDTH'(i);
         csr_wdata <= value;
         timing[i] = value;
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_fixed_timing(input cfg_array_type values);
      settle();
      for (int i = 0; i < REG_COUNT; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= REG_INDEX_WIDTH'(i);
         csr_wdata <= values[i];
         timing[i] = values[i];
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_ticks(input int count);
      repeat (count) send_tick(random_tick(), 1'b0, '0);
   endtask

   task automatic report(input string what);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch: %s", what);
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         report($sformatf("%s expected %0h got %0h", name, want, got));
   endtask

   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 19);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (bus_outcomes.size() == 0) begin
            report($sformatf("response %h with nothing expected", rsp_data));
         end else begin
            want = bus_outcomes.pop_front();
            check_field("drive_low", 8'(rsp_data.drive_low), 8'(want.drive_low));
            check_field("busy_res", 8'(rsp_data.busy_res), 8'(want.busy_res));
            check_field("done_res", 8'(rsp_data.done_res), 8'(want.done_res));
            check_field("presence_level", 8'(rsp_data.presence_level),
                        8'(want.presence_level));
            check_field("read_data", rsp_data.read_data, want.read_data);
         end
      end
   end

   initial begin
      clear_bus_state();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (boot_rows[i])
         repeat (boot_rows[i].reps)
            send_tick(boot_rows[i].stim, boot_rows[i].typed, boot_rows[i].want);

      load_fixed_timing(SHORT_TIMING);
      foreach (script[i])
         repeat (script[i].reps) send_tick(script[i].stim, script[i].typed, script[i].want);

      // Zero-valued registers act as a single tick.
      load_timing(0, 0);
      random_ticks(60);
      load_timing(1, 1);
      random_ticks(60);
      load_timing(1, 6);
      random_ticks(60);
      load_timing(0, 8);
      steady = 1'b1;
      random_ticks(120);
      steady = 1'b0;
      load_timing(1, 10);
      random_ticks(60);
      load_timing(2, 5);
      random_ticks(60);

      settle();
      if (mismatches == 0)
         $display("one_wire_bus_master_tb: PASS");
      else
         $display("one_wire_bus_master_tb: FAIL");
      $finish;
   end

endmodule
